### rtl/gnw_pkg.sv
`default_nettype none

package gnw_pkg;

  // map size and number formats
  localparam int MAX_UNITS       = 64;
  localparam int COORD_BITS      = 16;
  localparam int EXP_TABLE_DEPTH = 256;

  localparam int POS_W  = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int ADDR_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int CNT_W  = $clog2(MAX_UNITS + 1);

  // table index and the divider that produces it
  localparam int IDX_W     = $clog2(EXP_TABLE_DEPTH);
  localparam int DIV_STEPS = IDX_W + 1;
  localparam int REM_W     = 33 + IDX_W;
  localparam int ENT_W     = 17;
  localparam int PROD_W    = ENT_W + 8;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [1:0] CFG_SIGMA      = 2'd0;
  localparam logic [1:0] CFG_MAX_RADIUS = 2'd1;
  localparam logic [1:0] CFG_WEIGHT_MAX = 2'd2;
  localparam logic [1:0] CFG_WEIGHT_MIN = 2'd3;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DISABLED  = 3'd1,
    ST_BAD_SIGMA = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_LOAD_DONE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_RDI,
    S_WALK,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic       v;
    logic [5:0] j;
    logic [7:0] w;
  } link_res_t;

  typedef logic [EXP_TABLE_DEPTH-1:0][ENT_W-1:0] exp_tab_t;

  localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
  localparam logic [63:0] Q30_HALF = 64'd1 << 29;
  localparam logic [63:0] EXP_DEN  = 64'(4 * EXP_TABLE_DEPTH);

  function automatic logic [63:0] div_small(input logic [63:0] x, input int n);
    logic [63:0] r;
    r = x;
    unique case (n)
      1:       r = x;
      2:       r = x / 2;
      3:       r = x / 3;
      4:       r = x / 4;
      5:       r = x / 5;
      6:       r = x / 6;
      7:       r = x / 7;
      8:       r = x / 8;
      9:       r = x / 9;
      10:      r = x / 10;
      default: r = x;
    endcase
    return r;
  endfunction

  // exp(-4k/depth) in q16: taylor series on a sixteenth of the argument, squared four times
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] y;
    logic [63:0] e;
    logic [63:0] t;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      y = ((64'(k) << 30) + (EXP_DEN >> 1)) / EXP_DEN;
      e = Q30_ONE;
      t = Q30_ONE;
      for (int n = 1; n <= 10; n++) begin
        t = div_small((t * y + Q30_HALF) >> 30, n);
        if ((n % 2) == 1) begin
          e = (e > t) ? (e - t) : 64'd0;
        end else begin
          e = e + t;
        end
      end
      for (int r = 0; r < 4; r++) begin
        e = (e * e + Q30_HALF) >> 30;
      end
      tab[k] = ENT_W'((e + (64'd1 << 13)) >> 14);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

### rtl/gnw_link_pipe.sv
`default_nettype none

module gnw_link_pipe import gnw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  logic [5:0]         in_j,
  input  logic signed [15:0] pj_x,
  input  logic signed [15:0] pj_y,
  input  logic signed [15:0] pi_x,
  input  logic signed [15:0] pi_y,
  input  logic [31:0]        s2,
  input  logic [7:0]         wmax,
  input  logic [7:0]         wmin,
  output link_res_t          res,
  output logic               busy
);

  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [15:0]        ax;
  logic [15:0]        ay;

  logic        v1_r, v2_r, v3_r, vt_r, vp_r;
  logic [5:0]  j1_r, j2_r, j3_r, jt_r, jp_r;
  logic [15:0] ax_r, ay_r;
  logic [31:0] sx_r, sy_r;
  logic [32:0] d2_r;

  logic [32:0]          dd;
  logic [REM_W-1:0]     rem_r [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_r [DIV_STEPS+1];
  logic [5:0]           dj_r  [DIV_STEPS+1];
  logic [DIV_STEPS:0]   dv_r;
  logic [REM_W-1:0]     shf   [DIV_STEPS];
  logic [DIV_STEPS-1:0] ge;
  logic [DIV_STEPS-1:0] quo_f;

  logic [ENT_W-1:0]  ent_r;
  logic [PROD_W-1:0] pr_r;
  logic [PROD_W-1:0] rsum;
  logic [8:0]        w9;
  logic [7:0]        wclip;
  logic [12:0]       w20;
  logic              keep;

  // absolute coordinate differences
  assign dx = 17'(pj_x) - 17'(pi_x);
  assign dy = 17'(pj_y) - 17'(pi_y);
  assign ax = dx[16] ? 16'(-dx) : 16'(dx);
  assign ay = dy[16] ? 16'(-dy) : 16'(dy);

  assign dd = {s2, 1'b0};

  always_comb begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      shf[s] = REM_W'(dd) << (DIV_STEPS - 1 - s);
      ge[s]  = rem_r[s] >= shf[s];
    end
  end

  assign quo_f = quo_r[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      dv_r <= '0;
      vt_r <= 1'b0;
      vp_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      dv_r <= {dv_r[DIV_STEPS-1:0], v3_r};
      vt_r <= dv_r[DIV_STEPS];
      vp_r <= vt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j1_r <= in_j;
      ax_r <= ax;
      ay_r <= ay;

      j2_r <= j1_r;
      sx_r <= ax_r * ax_r;
      sy_r <= ay_r * ay_r;

      j3_r <= j2_r;
      d2_r <= 33'(sx_r) + 33'(sy_r);

      // numerator of the rounded table index
      rem_r[0] <= (REM_W'(d2_r) << (IDX_W - 2)) + REM_W'(s2);
      quo_r[0] <= '0;
      dj_r[0]  <= j3_r;

      // restoring divider, top quotient bit flags an index past the table
      for (int s = 0; s < DIV_STEPS; s++) begin
        rem_r[s+1] <= ge[s] ? (rem_r[s] - shf[s]) : rem_r[s];
        quo_r[s+1] <= quo_r[s] | (ge[s] ? (DIV_STEPS'(1) << (DIV_STEPS - 1 - s))
                                        : DIV_STEPS'(0));
        dj_r[s+1]  <= dj_r[s];
      end

      jt_r  <= dj_r[DIV_STEPS];
      ent_r <= quo_f[IDX_W] ? ENT_W'(0) : EXP_TAB[quo_f[IDX_W-1:0]];

      jp_r <= jt_r;
      pr_r <= PROD_W'(ent_r) * PROD_W'(wmax);
    end
  end

  assign rsum  = pr_r + PROD_W'(32768);
  assign w9    = rsum[PROD_W-1:16];
  assign wclip = (w9 > {1'b0, wmax}) ? wmax : w9[7:0];
  assign w20   = 13'(wclip) * 13'd20;
  assign keep  = (w20 >= 13'(wmax)) && (wclip >= wmin);

  assign res.v = vp_r && keep;
  assign res.j = jp_r;
  assign res.w = wclip;

  assign busy = v1_r || v2_r || v3_r || (|dv_r) || vt_r || vp_r;

endmodule

`default_nettype wire

### rtl/gaussian_neighbor_weights.sv
`default_nettype none

// channel  direction  handshake               payload
// in       input      in_valid / in_stall     kind, unit_index, coord_x, coord_y
// out      output     out_valid / out_stall   status, neighbor_index, link_weight, last
// cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// a load or a query ending in a status gives its single transaction from the S_EMIT state
// a full query reads each stored unit in turn from the position memory, then the distance,
// divider and table pipeline drains
// one item is in work at a time; in_stall stays high until the item's last transaction is
// in the output register
// reset (rst_n low, synchronous) clears the loaded count and the control state and sets the
// configuration to zero but weight_max to 255; the position memory holds whatever it had
// a stall on the output freezes the whole query pipeline, memory read included

module gaussian_neighbor_weights import gnw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [5:0]         in_unit_index,
  input  logic signed [15:0] in_coord_x,
  input  logic signed [15:0] in_coord_y,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [5:0]         out_neighbor_index,
  output logic [7:0]         out_link_weight,
  output logic               out_last,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // configuration
  logic [15:0] sigma_r;
  logic [15:0] max_radius_r;
  logic [7:0]  weight_max_r;
  logic [7:0]  weight_min_r;

  state_t state_r, state_nxt;

  logic             adv;
  logic             in_acc;
  logic             ld_ok;
  logic             q_known;
  logic             imm_walk;
  status_t          imm_st;
  logic [5:0]       imm_j;
  logic [7:0]       imm_w;

  // position memory, x in the upper half
  logic [2*POS_W-1:0] pos_mem [MAX_UNITS];
  logic [2*POS_W-1:0] rd_data_r;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_v_r;
  logic [5:0]         rd_j_r;
  logic signed [POS_W-1:0] rd_xn;
  logic signed [POS_W-1:0] rd_yn;
  logic signed [15:0] rd_x;
  logic signed [15:0] rd_y;

  logic [CNT_W-1:0] units_loaded_r;
  logic [CNT_W-1:0] j_r;
  logic             walk_issue;
  logic             walk_end;

  logic signed [15:0] pi_x_r;
  logic signed [15:0] pi_y_r;
  logic [31:0]        s2_r;

  status_t    one_st_r;
  logic [5:0] one_j_r;
  logic [7:0] one_w_r;

  // one kept link held back until the next one shows whether it is the last
  logic       pend_v_r;
  logic [5:0] pend_j_r;
  logic [7:0] pend_w_r;
  logic       pend_clear;

  link_res_t res;
  logic      pipe_busy;
  logic      busy_all;

  logic       out_load;
  logic [2:0] out_st_nxt;
  logic [5:0] out_j_nxt;
  logic [7:0] out_w_nxt;
  logic       out_last_nxt;

  logic       out_valid_r;
  logic [2:0] out_status_r;
  logic [5:0] out_j_r;
  logic [7:0] out_w_r;
  logic       out_last_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r      <= '0;
      max_radius_r <= '0;
      weight_max_r <= 8'd255;
      weight_min_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIGMA:      sigma_r      <= cfg_data;
        CFG_MAX_RADIUS: max_radius_r <= cfg_data;
        CFG_WEIGHT_MAX: weight_max_r <= cfg_data[7:0];
        CFG_WEIGHT_MIN: weight_min_r <= cfg_data[7:0];
      endcase
    end
  end

  // decode of an accepted item: immediate single result or a neighbourhood walk
  assign ld_ok   = CNT_W'(in_unit_index) < CNT_W'(MAX_UNITS);
  assign q_known = CNT_W'(in_unit_index) < units_loaded_r;

  always_comb begin
    imm_walk = 1'b0;
    imm_st   = ST_OK;
    imm_j    = '0;
    imm_w    = '0;
    priority if (in_kind == KIND_LOAD) begin
      imm_st = ld_ok ? ST_LOAD_DONE : ST_UNKNOWN;
      imm_j  = ld_ok ? in_unit_index : 6'd0;
    end else if (max_radius_r == 16'd0) begin
      imm_st = ST_DISABLED;
    end else if (sigma_r >= max_radius_r) begin
      imm_st = ST_BAD_SIGMA;
    end else if (!q_known) begin
      imm_st = ST_UNKNOWN;
    end else if (sigma_r == 16'd0) begin
      // self link only
      imm_st = ST_OK;
      imm_j  = in_unit_index;
      imm_w  = 8'd1;
    end else begin
      imm_walk = 1'b1;
    end
  end

  // memory: one write port for loads, one registered read port
  assign walk_issue = (state_r == S_WALK) && adv;
  assign walk_end   = walk_issue && (j_r == units_loaded_r - CNT_W'(1));
  assign rd_en      = in_acc || walk_issue;
  assign rd_addr    = (state_r == S_IDLE) ? in_unit_index[ADDR_W-1:0] : j_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (in_acc && (in_kind == KIND_LOAD) && ld_ok) begin
      pos_mem[in_unit_index[ADDR_W-1:0]] <= {in_coord_x[POS_W-1:0], in_coord_y[POS_W-1:0]};
    end
    if (rd_en) begin
      rd_data_r <= pos_mem[rd_addr];
    end
  end

  assign rd_xn = rd_data_r[2*POS_W-1:POS_W];
  assign rd_yn = rd_data_r[POS_W-1:0];
  assign rd_x  = 16'(rd_xn);
  assign rd_y  = 16'(rd_yn);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      units_loaded_r <= '0;
      rd_v_r         <= 1'b0;
    end else begin
      if (in_acc && (in_kind == KIND_LOAD) && ld_ok &&
          (CNT_W'(in_unit_index) + CNT_W'(1) > units_loaded_r)) begin
        units_loaded_r <= CNT_W'(in_unit_index) + CNT_W'(1);
      end
      if (adv) begin
        rd_v_r <= walk_issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      j_r      <= '0;
      one_st_r <= imm_st;
      one_j_r  <= imm_j;
      one_w_r  <= imm_w;
    end else if (walk_issue) begin
      j_r <= j_r + CNT_W'(1);
    end
    if (walk_issue) begin
      rd_j_r <= j_r[5:0];
    end
    // queried unit's position arrives in the cycle after acceptance, in S_RDI
    if (state_r == S_RDI) begin
      pi_x_r <= rd_x;
      pi_y_r <= rd_y;
      s2_r   <= sigma_r * sigma_r;
    end
  end

  gnw_link_pipe u_pipe (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .in_v  (rd_v_r),
    .in_j  (rd_j_r),
    .pj_x  (rd_x),
    .pj_y  (rd_y),
    .pi_x  (pi_x_r),
    .pi_y  (pi_y_r),
    .s2    (s2_r),
    .wmax  (weight_max_r),
    .wmin  (weight_min_r),
    .res   (res),
    .busy  (pipe_busy)
  );

  assign busy_all = pipe_busy || rd_v_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = imm_walk ? S_RDI : S_EMIT;
        end
      end
      S_EMIT: begin
        if (adv) begin
          state_nxt = S_IDLE;
        end
      end
      S_RDI: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (walk_end) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!busy_all && (!pend_v_r || adv)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall     = 1'b1;
    out_load     = 1'b0;
    out_st_nxt   = ST_OK;
    out_j_nxt    = pend_j_r;
    out_w_nxt    = pend_w_r;
    out_last_nxt = 1'b0;
    pend_clear   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_EMIT: begin
        out_load     = 1'b1;
        out_st_nxt   = one_st_r;
        out_j_nxt    = one_j_r;
        out_w_nxt    = one_w_r;
        out_last_nxt = 1'b1;
      end
      S_RDI: begin
        out_load = 1'b0;
      end
      S_WALK, S_DRAIN: begin
        if (res.v && pend_v_r) begin
          out_load = 1'b1;
        end else if ((state_r == S_DRAIN) && !busy_all && pend_v_r) begin
          // final kept link of the query
          out_load     = 1'b1;
          out_last_nxt = 1'b1;
          pend_clear   = 1'b1;
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pend_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (adv) begin
        if (res.v) begin
          pend_v_r <= 1'b1;
        end else if (pend_clear) begin
          pend_v_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.v) begin
      pend_j_r <= res.j;
      pend_w_r <= res.w;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && out_load) begin
      out_status_r <= out_st_nxt;
      out_j_r      <= out_j_nxt;
      out_w_r      <= out_w_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_neighbor_index = out_j_r;
  assign out_link_weight    = out_w_r;
  assign out_last           = out_last_r;

endmodule

`default_nettype wire
